// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, ignored while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check sampled on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dmar_pkg.sv =====
// Shared types, constants and helpers of the DMA descriptor ring.
package dmar_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int WORD_W     = 32;
  localparam int LEN_W      = 12;
  localparam int SLOT_W     = 8;
  localparam int HEAD_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WORD_W-1:0] OWN_BIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_DELIVER  = 2'd2,
    KIND_RSVD     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOT_DONE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECEIVE_MODE = 2'd0,
    CFG_SIZE_FLAGS   = 2'd1
  } cfg_idx_t;

  // Write request of one descriptor field store, also registered for the write bypass.
  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } wr_req_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== rtl/dmar_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module dmar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/dma_descriptor_ring.sv =====
// Top level of the DMA descriptor ring with ownership bit.
//
// Usage: software issues one transaction per item on the input channel: an insert
// of a descriptor at the tail, a completion that writes back the size word of a
// slot as the engine would, or a deliver that hands back the head descriptor.
// An item is taken at a rising edge with start high and busy low; busy is never
// raised, so one item can be taken in every cycle.
// Every item yields exactly one result transaction, shown for a single cycle with
// out_strobe high. The item passes from the input register through the execute
// stage to the result register, and the sustained rate is one item per cycle,
// set by the single execute stage that follows the input register.
// The three descriptor stores are RAMs with two read ports: both the head slot
// and the slot after it are read ahead, and a one-entry write bypass covers the
// write made by the item just before.
// The receiver cannot stall: a result is lost if nobody looks at it.
// Configuration (receive mode, size flag bits) is written via cfg_we, cfg_index
// and cfg_wdata; the user must do so only while no item is in flight (unchecked).
// Synchronous active-low reset empties the ring: head, tail and count go to
// zero and both configuration registers clear. Descriptor contents are not
// cleared; only slots that an insert wrote are ever delivered.

`include "assert_macros.svh"

module dma_descriptor_ring (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [dmar_pkg::WORD_W-1:0]    in_buffer_address,
  input  logic [dmar_pkg::LEN_W-1:0]     in_buffer_length,
  input  logic [dmar_pkg::WORD_W-1:0]    in_tag_word,
  input  logic [dmar_pkg::SLOT_W-1:0]    in_slot_index,
  input  logic [dmar_pkg::WORD_W-1:0]    in_status_word,
  // Result channel.
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic [dmar_pkg::WORD_W-1:0]    out_address,
  output logic [dmar_pkg::LEN_W-1:0]     out_length,
  output logic [dmar_pkg::WORD_W-1:0]    out_tag,
  output logic [dmar_pkg::COUNT_W-1:0]   out_entry_count,
  output logic [dmar_pkg::HEAD_W-1:0]    out_head_slot,
  // Configuration port.
  input  logic                           cfg_we,
  input  logic [dmar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmar_pkg::WORD_W-1:0]    cfg_wdata
);

  import dmar_pkg::*;

  // Configuration registers.
  logic              rx_mode_r;
  logic [WORD_W-1:0] size_flags_r;

  // Input register of the execute stage.
  logic              e_valid_r;
  kind_t             kind_r;
  logic [WORD_W-1:0] buf_addr_r;
  logic [LEN_W-1:0]  buf_len_r;
  logic [WORD_W-1:0] tag_word_r;
  logic [SLOT_W-1:0] slot_idx_r;
  logic [WORD_W-1:0] status_word_r;

  // Ring pointers and count.
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;

  // Set when the item executed in the previous cycle advanced the head.
  logic              adv_r, adv_nxt;

  // Store write requests of this cycle and the ones made in the previous cycle.
  wr_req_t           addr_wr, size_wr, tag_wr;
  wr_req_t           addr_byp_r, size_byp_r, tag_byp_r;

  // Read-ahead data at the head and at the slot after it.
  logic [PTR_W-1:0]  rd_ptr_b;
  logic [WORD_W-1:0] addr_rd_a, addr_rd_b;
  logic [WORD_W-1:0] size_rd_a, size_rd_b;
  logic [WORD_W-1:0] tag_rd_a, tag_rd_b;
  logic [WORD_W-1:0] head_addr, head_size, head_tag;

  // Result of the execute stage and the result register.
  status_t           res_status;
  logic [WORD_W-1:0] res_addr, res_tag;
  logic [LEN_W-1:0]  res_len;
  logic              engine_owns;

  logic              out_strobe_r;
  status_t           out_status_r;
  logic [WORD_W-1:0] out_addr_r, out_tag_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [HEAD_W-1:0] out_head_r;

  // Every item is executed without waiting, so the block never holds off.
  assign busy = 1'b0;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_mode_r    <= 1'b0;
      size_flags_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RECEIVE_MODE: rx_mode_r    <= cfg_wdata[0];
        CFG_SIZE_FLAGS:   size_flags_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: the item's fields are payload, the valid bit is control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r        <= kind_t'(in_kind);
      buf_addr_r    <= in_buffer_address;
      buf_len_r     <= in_buffer_length;
      tag_word_r    <= in_tag_word;
      slot_idx_r    <= in_slot_index;
      status_word_r <= in_status_word;
    end
  end

  // The stores are read every cycle at the head and at the slot after it. The
  // item now executing may move the head by one, which the next item sees.
  assign rd_ptr_b = next_slot(head_r);

  dmar_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_addr_ram (
    .clk     (clk),
    .we      (addr_wr.en),
    .waddr   (addr_wr.addr),
    .wdata   (addr_wr.data),
    .raddr_a (head_r),
    .raddr_b (rd_ptr_b),
    .rdata_a (addr_rd_a),
    .rdata_b (addr_rd_b)
  );

  dmar_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_size_ram (
    .clk     (clk),
    .we      (size_wr.en),
    .waddr   (size_wr.addr),
    .wdata   (size_wr.data),
    .raddr_a (head_r),
    .raddr_b (rd_ptr_b),
    .rdata_a (size_rd_a),
    .rdata_b (size_rd_b)
  );

  dmar_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_tag_ram (
    .clk     (clk),
    .we      (tag_wr.en),
    .waddr   (tag_wr.addr),
    .wdata   (tag_wr.data),
    .raddr_a (head_r),
    .raddr_b (rd_ptr_b),
    .rdata_a (tag_rd_a),
    .rdata_b (tag_rd_b)
  );

  // Pick the read-ahead word for the current head, then let the write made in
  // the previous cycle win, since the registered read did not yet see it.
  always_comb begin
    head_addr = adv_r ? addr_rd_b : addr_rd_a;
    head_size = adv_r ? size_rd_b : size_rd_a;
    head_tag  = adv_r ? tag_rd_b  : tag_rd_a;
    if (addr_byp_r.en && (addr_byp_r.addr == head_r)) begin
      head_addr = addr_byp_r.data;
    end
    if (size_byp_r.en && (size_byp_r.addr == head_r)) begin
      head_size = size_byp_r.data;
    end
    if (tag_byp_r.en && (tag_byp_r.addr == head_r)) begin
      head_tag = tag_byp_r.data;
    end
  end

  // In a receive ring the engine owns a slot while EMPTY is set; in a transmit
  // ring it owns the slot until it sets EMPTY.
  assign engine_owns = rx_mode_r ? ((head_size & OWN_BIT) != '0)
                                 : ((head_size & OWN_BIT) == '0);

  // Execute stage.
  always_comb begin
    res_status = ST_OK;
    res_addr   = '0;
    res_len    = '0;
    res_tag    = '0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    adv_nxt    = 1'b0;
    addr_wr    = '{en: 1'b0, addr: tail_r, data: buf_addr_r};
    size_wr    = '{en: 1'b0, addr: tail_r, data: '0};
    tag_wr     = '{en: 1'b0, addr: tail_r, data: tag_word_r};
    if (e_valid_r) begin
      unique case (kind_r)
        KIND_INSERT: begin
          if (occ_r >= CNT_W'(RING_DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            addr_wr.en   = 1'b1;
            tag_wr.en    = 1'b1;
            size_wr.en   = 1'b1;
            size_wr.data = {{(WORD_W - LEN_W){1'b0}}, buf_len_r} | size_flags_r
                           | (rx_mode_r ? OWN_BIT : '0);
            tail_nxt     = next_slot(tail_r);
            occ_nxt      = occ_r + 1'b1;
          end
        end
        KIND_COMPLETE: begin
          // A slot number past the end of the ring is dropped.
          if (32'(slot_idx_r) < RING_DEPTH) begin
            size_wr.en   = 1'b1;
            size_wr.addr = PTR_W'(slot_idx_r);
            size_wr.data = status_word_r;
          end
        end
        KIND_DELIVER: begin
          if (occ_r == '0) begin
            res_status = ST_EMPTY;
          end else if (engine_owns) begin
            res_status = ST_NOT_DONE;
          end else begin
            res_addr    = head_addr;
            res_len     = head_size[LEN_W-1:0];
            res_tag     = head_tag;
            tag_wr.en   = 1'b1;
            tag_wr.addr = head_r;
            tag_wr.data = '0;
            head_nxt    = next_slot(head_r);
            occ_nxt     = occ_r - 1'b1;
            adv_nxt     = 1'b1;
          end
        end
        KIND_RSVD: ;
        default: ;
      endcase
    end
  end

  // Ring state, head-advance flag and write bypass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      occ_r         <= '0;
      adv_r         <= 1'b0;
      addr_byp_r.en <= 1'b0;
      size_byp_r.en <= 1'b0;
      tag_byp_r.en  <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      occ_r         <= occ_nxt;
      adv_r         <= adv_nxt;
      addr_byp_r.en <= addr_wr.en;
      size_byp_r.en <= size_wr.en;
      tag_byp_r.en  <= tag_wr.en;
    end
    addr_byp_r.addr <= addr_wr.addr;
    addr_byp_r.data <= addr_wr.data;
    size_byp_r.addr <= size_wr.addr;
    size_byp_r.data <= size_wr.data;
    tag_byp_r.addr  <= tag_wr.addr;
    tag_byp_r.data  <= tag_wr.data;
  end

  // Result register: one transaction per executed item, shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= res_status;
    out_addr_r   <= res_addr;
    out_len_r    <= res_len;
    out_tag_r    <= res_tag;
    out_count_r  <= COUNT_W'(occ_nxt);
    out_head_r   <= HEAD_W'(head_nxt);
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_address     = out_addr_r;
  assign out_length      = out_len_r;
  assign out_tag         = out_tag_r;
  assign out_entry_count = out_count_r;
  assign out_head_slot   = out_head_r;

  // Checks on the ring bookkeeping and the result timing.
  `ASSERT_RST(a_occ_bound, clk, rst_n, occ_r <= CNT_W'(RING_DEPTH), "ring count past depth")
  `ASSERT_RST(a_ptr_meet, clk, rst_n, (occ_r == '0 || occ_r == CNT_W'(RING_DEPTH)) |-> (head_r == tail_r), "head and tail disagree with count")
  `ASSERT_RST(a_full_count, clk, rst_n, (out_strobe && out_status == ST_FULL) |-> (out_entry_count == COUNT_W'(RING_DEPTH)), "full reported on a ring with room")
  `ASSERT_RST(a_result_follows, clk, rst_n, e_valid_r |=> out_strobe, "executed item gave no result")
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_strobe, "result shown right after reset")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the DMA descriptor ring: directed table, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dmar_pkg::*;

  // One input transaction as the software side issues it.
  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] tag;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] sword;
  } ring_item_t;

  // One result transaction as the ring reports it.
  typedef struct packed {
    status_t            st;
    logic [WORD_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [WORD_W-1:0]  tag;
    logic [COUNT_W-1:0] count;
    logic [HEAD_W-1:0]  head;
  } ring_result_t;

  // A row of the directed table. When typed is set, the result written in the row is
  // what must come back; otherwise the shadow ring decides.
  typedef struct packed {
    ring_item_t   it;
    bit           typed;
    ring_result_t res;
  } directed_row_t;

  localparam ring_result_t PREDICTED = '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd0, 8'd0};
  localparam int DIRECTED_N = 21;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 500;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_kind = '0;
  logic [WORD_W-1:0]    in_buffer_address = '0;
  logic [LEN_W-1:0]     in_buffer_length = '0;
  logic [WORD_W-1:0]    in_tag_word = '0;
  logic [SLOT_W-1:0]    in_slot_index = '0;
  logic [WORD_W-1:0]    in_status_word = '0;
  logic                 out_strobe;
  logic [1:0]           out_status;
  logic [WORD_W-1:0]    out_address;
  logic [LEN_W-1:0]     out_length;
  logic [WORD_W-1:0]    out_tag;
  logic [COUNT_W-1:0]   out_entry_count;
  logic [HEAD_W-1:0]    out_head_slot;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  dma_descriptor_ring DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_buffer_address (in_buffer_address),
    .in_buffer_length  (in_buffer_length),
    .in_tag_word       (in_tag_word),
    .in_slot_index     (in_slot_index),
    .in_status_word    (in_status_word),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_address       (out_address),
    .out_length        (out_length),
    .out_tag           (out_tag),
    .out_entry_count   (out_entry_count),
    .out_head_slot     (out_head_slot),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Shadow copy of the ring. The descriptor stores start unknown on purpose: only
  // slots that an insert wrote may ever be delivered, so an X here would expose a
  // read of a stale slot.
  logic [WORD_W-1:0]  shadow_addr [RING_DEPTH];
  logic [WORD_W-1:0]  shadow_size [RING_DEPTH];
  logic [WORD_W-1:0]  shadow_tag  [RING_DEPTH];
  logic [HEAD_W-1:0]  ring_head;
  logic [HEAD_W-1:0]  ring_tail;
  logic [COUNT_W-1:0] ring_count;
  logic               rx_mode;
  logic [WORD_W-1:0]  flag_bits;

  // Results still owed by the ring, oldest first.
  ring_result_t  pending_results [$];
  directed_row_t directed_rows [DIRECTED_N];
  int            failures = 0;
  int            no_idle_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one accepted transaction to the shadow ring and returns the result it
  // must produce. The ring depth is 256, so the 8-bit pointers wrap by themselves.
  function automatic ring_result_t ring_apply(input ring_item_t it);
    ring_result_t      r;
    logic [WORD_W-1:0] sw;
    r = PREDICTED;
    case (it.kind)
      KIND_INSERT: begin
        if (ring_count >= RING_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          sw = {{(WORD_W-LEN_W){1'b0}}, it.len} | flag_bits;
          // A receive ring hands a fresh descriptor straight to the engine.
          if (rx_mode) sw = sw | OWN_BIT;
          shadow_addr[ring_tail] = it.addr;
          shadow_tag[ring_tail]  = it.tag;
          shadow_size[ring_tail] = sw;
          ring_tail  = ring_tail + 1'b1;
          ring_count = ring_count + 1'b1;
        end
      end
      KIND_COMPLETE: begin
        shadow_size[it.slot] = it.sword;
      end
      KIND_DELIVER: begin
        if (ring_count == 0) begin
          r.st = ST_EMPTY;
        end else if (shadow_size[ring_head][WORD_W-1] == rx_mode) begin
          // The engine still owns the head: set for receive, clear for transmit.
          r.st = ST_NOT_DONE;
        end else begin
          r.len  = shadow_size[ring_head][LEN_W-1:0];
          r.addr = shadow_addr[ring_head];
          r.tag  = shadow_tag[ring_head];
          shadow_tag[ring_head] = '0;
          ring_head  = ring_head + 1'b1;
          ring_count = ring_count - 1'b1;
        end
      end
      default: ;
    endcase
    r.count = ring_count;
    r.head  = ring_head;
    return r;
  endfunction

  function automatic ring_item_t random_fields(input kind_t k);
    ring_item_t it;
    it.kind  = k;
    it.addr  = $urandom;
    it.len   = LEN_W'($urandom);
    it.tag   = $urandom;
    it.slot  = SLOT_W'($urandom);
    it.sword = $urandom;
    return it;
  endfunction

  // Presents one transaction after a random gap and waits for the ring to take it.
  // Start is left high on return so that back-to-back items need no extra edge.
  task automatic send_item(input ring_item_t it, input bit typed, input ring_result_t fixed);
    int           gap;
    int           pick;
    ring_result_t res;
    gap = 0;
    if (no_idle_left > 0) begin
      no_idle_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) no_idle_left = $urandom_range(20, 60);
      else if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_kind           <= it.kind;
    in_buffer_address <= it.addr;
    in_buffer_length  <= it.len;
    in_tag_word       <= it.tag;
    in_slot_index     <= it.slot;
    in_status_word    <= it.sword;
    do @(posedge clk); while (busy);
    // The shadow ring advances at the accepting edge, so later items are drawn
    // from the state the hardware now holds.
    res = ring_apply(it);
    pending_results.push_back(typed ? fixed : res);
  endtask

  // Drains the ring's pipeline, then writes both registers. The shadow copy follows
  // at once since no transaction is in flight.
  task automatic configure(input logic mode, input logic [WORD_W-1:0] flags);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RECEIVE_MODE;
    cfg_wdata <= {(WORD_W-1)'($urandom), mode};
    @(posedge clk);
    cfg_index <= CFG_SIZE_FLAGS;
    cfg_wdata <= flags;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rx_mode   = mode;
    flag_bits = flags;
  endtask

  // Mixed traffic. Completions mostly target outstanding slots and mostly pass
  // ownership back to software, so that delivers get through often.
  task automatic run_mixed(input int n_items);
    ring_item_t it;
    int         pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        it = random_fields(KIND_RSVD);
      end else if (pick < 40) begin
        it = random_fields(KIND_INSERT);
      end else if (pick < 65) begin
        it = random_fields(KIND_COMPLETE);
        if (ring_count != 0 && $urandom_range(0, 3) != 0)
          it.slot = ring_head + SLOT_W'($urandom_range(0, ring_count - 1));
        if ($urandom_range(0, 4) != 0) it.sword[WORD_W-1] = ~rx_mode;
      end else begin
        it = random_fields(KIND_DELIVER);
      end
      send_item(it, 1'b0, PREDICTED);
    end
  endtask

  // Fills the ring to the brim, knocks on it while it is full, then empties it.
  // Whenever the head is still owned by the engine, a completion releases it first.
  task automatic fill_and_drain();
    ring_item_t it;
    while (ring_count < RING_DEPTH) begin
      it = random_fields(KIND_INSERT);
      if ($urandom_range(0, 19) == 0) it.kind = KIND_RSVD;
      send_item(it, 1'b0, PREDICTED);
    end
    repeat (3) send_item(random_fields(KIND_INSERT), 1'b0, PREDICTED);
    while (ring_count != 0) begin
      it = random_fields(KIND_DELIVER);
      if ($urandom_range(0, 19) == 0) begin
        it.kind = KIND_RSVD;
      end else if (shadow_size[ring_head][WORD_W-1] == rx_mode) begin
        it.kind = KIND_COMPLETE;
        it.slot = ring_head;
        it.sword[WORD_W-1] = ~rx_mode;
      end
      send_item(it, 1'b0, PREDICTED);
    end
  endtask

  // Every result transaction is checked against the oldest one still owed. The
  // receiver cannot stall, so each strobe is consumed in the cycle it appears.
  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result transaction arrived with none outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_status);
          failures++;
        end
        if (out_address !== want.addr) begin
          $error("out_address: expected %h, got %h", want.addr, out_address);
          failures++;
        end
        if (out_length !== want.len) begin
          $error("out_length: expected %h, got %h", want.len, out_length);
          failures++;
        end
        if (out_tag !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, out_tag);
          failures++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          failures++;
        end
        if (out_head_slot !== want.head) begin
          $error("head_slot: expected %0d, got %0d", want.head, out_head_slot);
          failures++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int k;

    // The directed rows run on a transmit ring with no flag bits, so ownership is
    // plain: a fresh descriptor belongs to the engine until a completion sets EMPTY.
    directed_rows = '{
      // Deliver from an empty ring right after reset.
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b1,
        '{ST_EMPTY, 32'h0, 12'h0, 32'h0, 9'd0, 8'd0}},
      // The reserved kind is ignored even with every field at its maximum.
      '{'{KIND_RSVD, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
        '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd0, 8'd0}},
      // A completion on the last slot changes no pointer.
      '{'{KIND_COMPLETE, 32'h0, 12'h0, 32'h0, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
        '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd0, 8'd0}},
      '{'{KIND_INSERT, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 8'h00, 32'h0}, 1'b1,
        '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd1, 8'd0}},
      // The engine still owns the head.
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b1,
        '{ST_NOT_DONE, 32'h0, 12'h0, 32'h0, 9'd1, 8'd0}},
      '{'{KIND_COMPLETE, 32'h0, 12'h0, 32'h0, 8'h00, 32'h8000_0ABC}, 1'b1,
        '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd1, 8'd0}},
      // Length comes from the written-back size word, not from the insert.
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b1,
        '{ST_OK, 32'hFFFF_FFFF, 12'hABC, 32'hFFFF_FFFF, 9'd0, 8'd1}},
      '{'{KIND_INSERT, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b1,
        '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd1, 8'd1}},
      '{'{KIND_COMPLETE, 32'h0, 12'h0, 32'h0, 8'h01, 32'h8000_0000}, 1'b1,
        '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd1, 8'd1}},
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b1,
        '{ST_OK, 32'h0, 12'h0, 32'h0, 9'd0, 8'd2}},
      // Two descriptors, completed out of order.
      '{'{KIND_INSERT, 32'h1357_9BDF, 12'h5A5, 32'h0F0F_0001, 8'h00, 32'h0}, 1'b0, PREDICTED},
      '{'{KIND_INSERT, 32'h2468_ACE0, 12'h123, 32'h0F0F_0002, 8'h00, 32'h0}, 1'b0, PREDICTED},
      '{'{KIND_COMPLETE, 32'h0, 12'h0, 32'h0, 8'h03, 32'hFFFF_F000}, 1'b0, PREDICTED},
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b0, PREDICTED},
      '{'{KIND_COMPLETE, 32'h0, 12'h0, 32'h0, 8'h02, 32'h8000_0FFF}, 1'b0, PREDICTED},
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b0, PREDICTED},
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b0, PREDICTED},
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b0, PREDICTED},
      // A completion that leaves EMPTY clear keeps a transmit slot with the engine.
      '{'{KIND_INSERT, 32'hA5A5_5A5A, 12'h0F0, 32'h5A5A_A5A5, 8'h00, 32'h0}, 1'b0, PREDICTED},
      '{'{KIND_COMPLETE, 32'h0, 12'h0, 32'h0, 8'h04, 32'h7FFF_FFFF}, 1'b0, PREDICTED},
      '{'{KIND_DELIVER, 32'h0, 12'h0, 32'h0, 8'h00, 32'h0}, 1'b0, PREDICTED}
    };

    ring_head  = '0;
    ring_tail  = '0;
    ring_count = '0;
    rx_mode    = 1'b0;
    flag_bits  = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    configure(1'b0, 32'h0);
    for (k = 0; k < DIRECTED_N; k++)
      send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].res);

    // The directed part leaves one descriptor outstanding, so the switch to a
    // receive ring below also covers a polarity change with entries in flight.
    configure(1'b1, $urandom);
    run_mixed(130);

    // With every flag bit set, a transmit descriptor is released as soon as it is
    // inserted, which lets the ring be filled and emptied in one sweep.
    configure(1'b0, 32'hFFFF_FFFF);
    fill_and_drain();

    configure(1'b1, 32'h0);
    run_mixed(130);
    configure(1'b0, 32'h0);
    run_mixed(130);
    configure(1'b0, $urandom);
    run_mixed(130);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dmar_pkg.sv
rtl/dmar_ram.sv
rtl/dma_descriptor_ring.sv
bench/testbench.sv
